// ----- sv/sjfs_pkg.sv -----
package sjfs_pkg;

    // default depth of the ready table
    localparam int SJFS_DEPTH = 16;

    // command codes
    localparam logic CMD_INSERT   = 1'b0;
    localparam logic CMD_SCHEDULE = 1'b1;

    // leaving process states
    localparam logic [1:0] PST_READY    = 2'd0;
    localparam logic [1:0] PST_BLOCKED  = 2'd1;
    localparam logic [1:0] PST_FINISHED = 2'd2;
    localparam logic [1:0] PST_INVALID  = 2'd3;

    // routing codes for the leaving process
    localparam logic [2:0] ROUTE_NONE     = 3'd0;
    localparam logic [2:0] ROUTE_READY    = 3'd1;
    localparam logic [2:0] ROUTE_BLOCKED  = 3'd2;
    localparam logic [2:0] ROUTE_FINISHED = 3'd3;
    localparam logic [2:0] ROUTE_ERROR    = 3'd4;

    // input word
    typedef struct packed {
        logic        command;
        logic        has_current;
        logic [1:0]  current_state;
        logic [7:0]  proc_id;
        logic [15:0] rem_time;
    } t_in_word;

    // result word
    typedef struct packed {
        logic        selected_valid;
        logic [7:0]  selected_id;
        logic [15:0] selected_time;
        logic [2:0]  routed_to;
        logic        table_full_drop;
    } t_out_word;

    // one table entry as seen by the neighbors
    typedef struct packed {
        logic        valid;
        logic [7:0]  id;
        logic [15:0] rem_time;
    } t_entry;

    // row-wide control broadcast to every cell
    typedef struct packed {
        logic        ins;
        logic        pop;
        logic [7:0]  id;
        logic [15:0] rem_time;
    } t_cell_ctl;

endpackage

// ----- sv/sjfs_cell.sv -----
module sjfs_cell
    import sjfs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_entry    i_left,
    input  logic      i_left_gt,
    input  t_entry    i_right,
    output t_entry    o_entry,
    output logic      o_gt
);

    logic        r_valid;
    logic [7:0]  r_id;
    logic [15:0] r_time;

    t_entry n_entry;
    logic   w_load;

    // new item goes in front of this entry (empty slot counts as larger)
    assign o_gt = !r_valid || (r_time > i_ctl.rem_time);

    assign o_entry = '{valid: r_valid, id: r_id, rem_time: r_time};

    // next contents: shift left on pop, shift right or take new item on insert
    always_comb begin
        n_entry = o_entry;
        w_load  = 1'b0;
        if (i_ctl.pop) begin
            n_entry = i_right;
            w_load  = 1'b1;
        end else if (i_ctl.ins && o_gt) begin
            w_load = 1'b1;
            if (i_left_gt) begin
                n_entry = i_left;
            end else begin
                n_entry = '{valid: 1'b1, id: i_ctl.id, rem_time: i_ctl.rem_time};
            end
        end
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= n_entry.valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_id   <= n_entry.id;
            r_time <= n_entry.rem_time;
        end
    end

endmodule

// ----- sv/shortest_job_first_selector.sv -----
// Shortest-job-first selector. The ready table is a row of TABLE_DEPTH cells kept
// sorted by remaining time, equal times in arrival order, so the head cell always
// holds the next process to run. For an insert word every cell compares the new
// time with its own and the row opens a gap in a single shift. A schedule word
// has a routing step and a pop step: the first routes the leaving process (a
// ready one is put back through the same insert shift), the second pops the head
// while the row shifts one place toward the front. Each word gives one result
// word, held in an output register; a new word is taken once no pop step is pending
// and that register is free or being taken. No clearing pass is needed after reset.
// An insert into a full table is dropped and flagged in table_full_drop.
module shortest_job_first_selector
    import sjfs_pkg::*;
#(
    parameter int TABLE_DEPTH = SJFS_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    typedef enum logic {
        S_IDLE,
        S_POP
    } t_state;

    t_state    r_state;
    logic      r_out_valid;
    t_out_word r_out;
    logic [2:0] r_routed;
    logic      r_drop;

    t_entry    w_entry [TABLE_DEPTH];
    logic      w_gt    [TABLE_DEPTH];
    t_cell_ctl w_ctl;
    logic      w_accept;
    logic      w_full;
    logic      w_put_back;
    logic [2:0] w_route;
    logic      w_out_load;

    assign w_full = w_entry[TABLE_DEPTH-1].valid;

    // handshake
    assign o_in_stall  = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // result register is loaded by an insert word or by the pop step
    assign w_out_load = (w_accept && i_in_word.command == CMD_INSERT) ||
                        (r_state == S_POP);

    // routing of the leaving process
    always_comb begin
        w_put_back = 1'b0;
        w_route    = ROUTE_NONE;
        if (i_in_word.has_current) begin
            case (i_in_word.current_state)
                PST_READY: begin
                    w_route    = ROUTE_READY;
                    w_put_back = 1'b1;
                end
                PST_BLOCKED:  w_route = ROUTE_BLOCKED;
                PST_FINISHED: w_route = ROUTE_FINISHED;
                default:      w_route = ROUTE_ERROR;
            endcase
        end
    end

    // row control
    always_comb begin
        w_ctl.ins = w_accept && !w_full &&
                    (i_in_word.command == CMD_INSERT || w_put_back);
        w_ctl.pop = (r_state == S_POP);
        w_ctl.id  = i_in_word.proc_id;
        w_ctl.rem_time = i_in_word.rem_time;
    end

    // row of cells
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        t_entry w_left;
        t_entry w_right;
        logic   w_left_gt;

        if (g == 0) begin : g_first
            assign w_left    = '0;
            assign w_left_gt = 1'b0;
        end else begin : g_mid
            assign w_left    = w_entry[g-1];
            assign w_left_gt = w_gt[g-1];
        end

        if (g == TABLE_DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_entry[g+1];
        end

        sjfs_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_left    (w_left),
            .i_left_gt (w_left_gt),
            .i_right   (w_right),
            .o_entry   (w_entry[g]),
            .o_gt      (w_gt[g])
        );
    end

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_in_word.command == CMD_INSERT) begin
                            r_out.selected_valid  <= 1'b0;
                            r_out.selected_id     <= '0;
                            r_out.selected_time   <= '0;
                            r_out.routed_to       <= ROUTE_NONE;
                            r_out.table_full_drop <= w_full;
                        end else begin
                            r_routed <= w_route;
                            r_drop   <= w_put_back && w_full;
                            r_state  <= S_POP;
                        end
                    end
                end
                S_POP: begin
                    r_out.selected_valid  <= w_entry[0].valid;
                    r_out.selected_id     <= w_entry[0].valid ? w_entry[0].id : '0;
                    r_out.selected_time   <= w_entry[0].valid ? w_entry[0].rem_time : '0;
                    r_out.routed_to       <= r_routed;
                    r_out.table_full_drop <= r_drop;
                    r_state               <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // the pop step is followed by idle and always leaves a result
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_POP |=> r_state == S_IDLE && r_out_valid)
        else $error("pop step did not produce a result");

    // no insert shift into a full row
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.ins |-> !w_full)
        else $error("insert into full table");

    // insert and pop never overlap
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ctl.ins && w_ctl.pop))
        else $error("insert and pop in the same cycle");

    // head of the row holds the smallest time
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_entry[0].valid && w_entry[1].valid |->
            w_entry[0].rem_time <= w_entry[1].rem_time)
        else $error("table head out of order");

endmodule

// ----- tb/sjfs_checker.sv -----
`timescale 1ns / 100ps

// watches both channels of the selector, predicts every result word and
// compares it with what the block returns
module sjfs_checker
    import sjfs_pkg::*;
#(
    parameter int TABLE_DEPTH = SJFS_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_word  i_in_word,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_word i_out_word,
    output int        o_fail_count,
    output int        o_pending
);

    // ready processes in arrival order, oldest first
    t_entry    ready_q[$];
    // result words still owed by the block
    t_out_word owed_q[$];
    int        mismatches;

    initial mismatches = 0;
    assign o_fail_count = mismatches;

    // append a ready process, returns 1 when the table is full and it is lost
    function automatic logic enqueue_ready(input logic [7:0] id, input logic [15:0] rtime);
        t_entry e;
        if (ready_q.size() >= TABLE_DEPTH) begin
            return 1'b1;
        end
        e.valid    = 1'b1;
        e.id       = id;
        e.rem_time = rtime;
        ready_q.push_back(e);
        return 1'b0;
    endfunction

    // apply one input word to the predicted table and build its result word
    function automatic t_out_word sjf_decide(input t_in_word w);
        t_out_word r;
        int        best;
        r = '0;
        if (w.command == CMD_INSERT) begin
            r.table_full_drop = enqueue_ready(w.proc_id, w.rem_time);
        end else begin
            // route the process leaving the processor
            if (w.has_current) begin
                case (w.current_state)
                    PST_READY: begin
                        r.routed_to       = ROUTE_READY;
                        r.table_full_drop = enqueue_ready(w.proc_id, w.rem_time);
                    end
                    PST_BLOCKED:  r.routed_to = ROUTE_BLOCKED;
                    PST_FINISHED: r.routed_to = ROUTE_FINISHED;
                    default:      r.routed_to = ROUTE_ERROR;
                endcase
            end
            // shortest remaining time wins, earliest arrival on a tie
            if (ready_q.size() > 0) begin
                best = 0;
                for (int i = 1; i < ready_q.size(); i++) begin
                    if (ready_q[i].rem_time < ready_q[best].rem_time) begin
                        best = i;
                    end
                end
                r.selected_valid = 1'b1;
                r.selected_id    = ready_q[best].id;
                r.selected_time  = ready_q[best].rem_time;
                ready_q.delete(best);
            end
        end
        return r;
    endfunction

    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // compare results first, then predict the word taken at the same edge
    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            ready_q.delete();
            owed_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (owed_q.size() == 0) begin
                    $error("result word %h with no word pending", i_out_word);
                    mismatches++;
                end else begin
                    want = owed_q.pop_front();
                    compare_field("selected_valid", 32'(want.selected_valid),
                                  32'(i_out_word.selected_valid));
                    compare_field("selected_id", 32'(want.selected_id),
                                  32'(i_out_word.selected_id));
                    compare_field("selected_time", 32'(want.selected_time),
                                  32'(i_out_word.selected_time));
                    compare_field("routed_to", 32'(want.routed_to),
                                  32'(i_out_word.routed_to));
                    compare_field("table_full_drop", 32'(want.table_full_drop),
                                  32'(i_out_word.table_full_drop));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                owed_q.push_back(sjf_decide(i_in_word));
            end
        end
        o_pending <= owed_q.size();
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import sjfs_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 200;
    localparam int PHASE_WORDS    = 212;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_word  in_word;
    logic      out_valid;
    logic      out_stall;
    t_out_word out_word;
    int        fail_count;
    int        pending;

    // traffic shaping shared by the sender and the receiver
    int idle_pct;
    int stall_pct;
    int hold_req;
    int hold_seen;

    always #4 clk = ~clk;

    shortest_job_first_selector u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    sjfs_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic t_in_word make_word(input logic cmd, input logic hc,
                                           input logic [1:0] st, input logic [7:0] id,
                                           input logic [15:0] rtime);
        t_in_word w;
        w.command       = cmd;
        w.has_current   = hc;
        w.current_state = st;
        w.proc_id       = id;
        w.rem_time      = rtime;
        return w;
    endfunction

    // random word, insert share set by the caller, times biased toward ties and extremes
    function automatic t_in_word random_word(input int ins_pct);
        t_in_word w;
        int       pick;
        w.command     = ($urandom_range(99) < ins_pct) ? CMD_INSERT : CMD_SCHEDULE;
        w.has_current = ($urandom_range(3) != 0);
        pick = $urandom_range(99);
        if (pick < 45) begin
            w.current_state = PST_READY;
        end else if (pick < 65) begin
            w.current_state = PST_BLOCKED;
        end else if (pick < 85) begin
            w.current_state = PST_FINISHED;
        end else begin
            w.current_state = PST_INVALID;
        end
        w.proc_id = 8'($urandom_range(255));
        pick = $urandom_range(9);
        if (pick < 5) begin
            w.rem_time = 16'($urandom_range(16'hFFFF));
        end else if (pick < 8) begin
            w.rem_time = 16'($urandom_range(7));
        end else if (pick == 8) begin
            w.rem_time = 16'd0;
        end else begin
            w.rem_time = 16'hFFFF;
        end
        return w;
    endfunction

    // offer one word, with random gaps ahead of it, and wait until it is taken
    task automatic offer_word(input t_in_word w);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // receiver: random stall, or a long hold when one is requested
    initial begin
        out_stall <= 1'b0;
        hold_seen = 0;
        forever begin
            @(posedge clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                for (int k = 0; k < HOLD_CYCLES; k++) begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // watchdog on cycles with no word moving on either channel
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb: failure");
        $finish;
    end

    // stimulus and verdict
    initial begin
        int ins_pct;
        int phase_idle[4];
        int phase_stall[4];
        logic [15:0] t;
        phase_idle  = '{0, 74, 0, 17};
        phase_stall = '{0, 0, 74, 17};
        in_valid <= 1'b0;
        in_word  <= '0;
        rst_n    <= 1'b0;
        idle_pct  = 0;
        stall_pct = 0;
        hold_req  = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // schedule on an empty table, every leaving state
        offer_word(make_word(CMD_SCHEDULE, 1'b0, PST_READY, 8'd0, 16'd0));
        offer_word(make_word(CMD_SCHEDULE, 1'b1, PST_READY, 8'hFF, 16'hFFFF));
        offer_word(make_word(CMD_SCHEDULE, 1'b1, PST_BLOCKED, 8'h12, 16'd5));
        offer_word(make_word(CMD_SCHEDULE, 1'b1, PST_FINISHED, 8'h34, 16'd9));
        offer_word(make_word(CMD_SCHEDULE, 1'b1, PST_INVALID, 8'h56, 16'h8000));

        // fill the table with ties and extreme times, ignored fields toggling
        for (int i = 0; i < SJFS_DEPTH; i++) begin
            if (i == 1) begin
                t = 16'hFFFF;
            end else if (i == 2 || i == 9) begin
                t = 16'd0;
            end else begin
                t = 16'((i * 37) % 8 + 1);
            end
            offer_word(make_word(CMD_INSERT, i[0], i[1:0], 8'(i * 17), t));
        end
        // insert into a full table, then a ready process coming back to a full table
        offer_word(make_word(CMD_INSERT, 1'b0, PST_READY, 8'hAA, 16'd0));
        offer_word(make_word(CMD_SCHEDULE, 1'b1, PST_READY, 8'hBB, 16'd0));
        offer_word(make_word(CMD_SCHEDULE, 1'b1, PST_INVALID, 8'hCC, 16'd0));
        offer_word(make_word(CMD_SCHEDULE, 1'b0, PST_BLOCKED, 8'hDD, 16'hFFFF));

        // long hold on the result side while words keep coming
        hold_req = hold_req + 1;

        // random phases with varying insert share, idling and result-side stalls
        for (int p = 0; p < 4; p++) begin
            idle_pct  = phase_idle[p];
            stall_pct = phase_stall[p];
            ins_pct   = 50;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (n % 25 == 0) begin
                    case ($urandom_range(2))
                        0:       ins_pct = 25;
                        1:       ins_pct = 50;
                        default: ins_pct = 85;
                    endcase
                end
                offer_word(random_word(ins_pct));
            end
        end
        in_valid <= 1'b0;

        // drain the owed results, then let the block settle
        do @(posedge clk); while (pending != 0);
        repeat (20) @(posedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- shortest_job_first_selector.f -----
sv/sjfs_pkg.sv
sv/sjfs_cell.sv
sv/shortest_job_first_selector.sv
tb/sjfs_checker.sv
tb/testbench.sv
